FILE: rtl/modbus_rtu_frame_checker_macros.svh
// -----------------------------------------------------------------------------
// Modbus RTU frame checker assertion macros
// Shared concurrent assertion shorthands clocked on clk_i, disabled in reset.
// -----------------------------------------------------------------------------
`ifndef MODBUS_RTU_FRAME_CHECKER_MACROS_SVH
`define MODBUS_RTU_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication.
`define MRFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mrfc: same-cycle check failed");

// Next-cycle implication.
`define MRFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mrfc: next-cycle check failed");

`endif

FILE: rtl/mrfc_pkg.sv
// -----------------------------------------------------------------------------
// Modbus RTU frame checker package
// Constants, the result record and the byte-wise CRC-16 update.
// -----------------------------------------------------------------------------
package mrfc_pkg;

  localparam logic [7:0]  MAX_FRAME_BYTES = 8'd255;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  typedef struct packed {
    logic [7:0] echo_byte;
    logic [7:0] byte_position;
    logic       frame_good;
    logic [7:0] frame_length;
    logic       frame_abort;
  } res_t;

  // One byte through the reflected CRC-16, unrolled over its eight bits.
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

FILE: rtl/mrfc_frame_core.sv
// -----------------------------------------------------------------------------
// Modbus RTU frame checker core
// Frame state, delayed CRC update and trailer match for one byte per step.
// -----------------------------------------------------------------------------
module mrfc_frame_core import mrfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       crc_high_first_i,
  output res_t       res_o
);

`include "modbus_rtu_frame_checker_macros.svh"

  logic [15:0] crc_q, crc_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  last_q, last_d;
  logic [7:0]  second_q, second_d;

  logic        full;
  logic [15:0] crc_new;
  logic [7:0]  count_new;
  logic        match;

  always_comb begin
    full      = (count_q >= MAX_FRAME_BYTES);
    // The CRC trails the newest byte by two, so the byte leaving the
    // trailer window is folded in only once two bytes are held.
    crc_new   = (count_q >= 8'd2) ? crc16_feed(crc_q, second_q) : crc_q;
    count_new = count_q + 8'd1;
    if (crc_high_first_i) begin
      match = (count_new >= 8'd2) && (last_q == crc_new[15:8]) && (byte_i == crc_new[7:0]);
    end else begin
      match = (count_new >= 8'd2) && (last_q == crc_new[7:0]) && (byte_i == crc_new[15:8]);
    end

    res_o.echo_byte     = byte_i;
    res_o.byte_position = full ? 8'd0 : count_q;
    res_o.frame_good    = !full && match;
    res_o.frame_length  = (!full && match) ? count_new : 8'd0;
    res_o.frame_abort   = full;

    crc_d    = crc_q;
    count_d  = count_q;
    last_d   = last_q;
    second_d = second_q;
    if (step_i) begin
      if (full || match) begin
        crc_d    = CRC_INIT;
        count_d  = 8'd0;
        last_d   = 8'd0;
        second_d = 8'd0;
      end else begin
        crc_d    = crc_new;
        count_d  = count_new;
        last_d   = byte_i;
        second_d = last_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= CRC_INIT;
      count_q  <= 8'd0;
      last_q   <= 8'd0;
      second_q <= 8'd0;
    end else begin
      crc_q    <= crc_d;
      count_q  <= count_d;
      last_q   <= last_d;
      second_q <= second_d;
    end
  end

  `MRFC_ASSERT_NXT(a_good_restarts, step_i && res_o.frame_good, count_q == 8'd0)
  `MRFC_ASSERT_IMP(a_abort_only_full, res_o.frame_abort, count_q >= MAX_FRAME_BYTES)
  `MRFC_ASSERT_NXT(a_plain_byte_counts, step_i && !res_o.frame_good && !res_o.frame_abort,
                   count_q == $past(count_q) + 8'd1)

endmodule

FILE: rtl/modbus_rtu_frame_checker.sv
// -----------------------------------------------------------------------------
// Modbus RTU frame checker
// Counts received bytes into frames and flags frames whose CRC-16 trailer matches.
// -----------------------------------------------------------------------------
// Each byte received from the RS-485 line is taken on the rx channel and
// produces exactly one result transfer: the byte echoed with its position in
// the current frame, a good-frame flag with the frame length when the last two
// bytes equal the Modbus CRC-16 of all earlier bytes, and an abort flag when the
// byte arrived at a frame already holding MAX_FRAME_BYTES bytes (that byte is
// dropped and the frame restarts). The crc_high_first register selects the
// trailer byte order; it resets to low byte first and is written with cfg_we_i.
// Throughput is one byte per cycle while the result side does not stall; each
// byte passes through the input register and then the result register, with
// the unrolled eight-bit CRC step and trailer compare between the two.
// -----------------------------------------------------------------------------
module modbus_rtu_frame_checker import mrfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  // Received bytes
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  // Results
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic [7:0] echo_byte_o,
  output logic [7:0] byte_position_o,
  output logic       frame_good_o,
  output logic [7:0] frame_length_o,
  output logic       frame_abort_o
);

  logic       crc_high_first_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       res_valid_q;
  res_t       res_q;
  res_t       res_d;
  logic       advance;

  // The held byte moves into the result register whenever that register is
  // empty or its contents leave in this same cycle, so the pipeline never
  // stalls unless the result side does.
  assign advance    = in_valid_q && (!res_valid_q || res_ready_i);
  assign rx_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_high_first_q <= 1'b0;
    end else if (cfg_we_i) begin
      crc_high_first_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Frame state advances exactly once per byte, at the cycle the byte
  // moves into the result register.
  mrfc_frame_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (advance),
    .byte_i           (in_byte_q),
    .crc_high_first_i (crc_high_first_q),
    .res_o            (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign echo_byte_o     = res_q.echo_byte;
  assign byte_position_o = res_q.byte_position;
  assign frame_good_o    = res_q.frame_good;
  assign frame_length_o  = res_q.frame_length;
  assign frame_abort_o   = res_q.frame_abort;

endmodule
